// ----- hdl/assert_macros.svh -----
// assertion macros used by the decompressor rtl
// no dependencies; included by files that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the following cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/lzwd_pkg.sv -----
// shared types and constants for the lz window decompressor
// no dependencies; imported by the decoder, the top level and the testbench
package lzwd_pkg;

    localparam int WINDOW_BYTES = 4096;
    localparam int ADDR_W       = $clog2(WINDOW_BYTES);
    localparam int COUNT_W      = 24;
    localparam int LEN_W        = 5;
    localparam int FLAGS_W      = 5;
    localparam int WORD_W       = 16;
    localparam int BYTE_W       = 8;

    localparam logic [LEN_W-1:0]   MATCH_LEN_BASE = LEN_W'(18);
    localparam logic [FLAGS_W-1:0] FLAGS_PER_CTRL = FLAGS_W'(16);
    localparam logic [COUNT_W-1:0] MAX_BYTES_RST  = {COUNT_W{1'b1}};

    // kind of word: what an item is, and what is expected next
    typedef enum logic [1:0] {
        KIND_LITERAL = 2'd0,
        KIND_MATCH   = 2'd1,
        KIND_CONTROL = 2'd2
    } t_kind;

    // everything the top level needs to run one item
    typedef struct packed {
        t_kind                kind;
        logic [LEN_W-1:0]     len;
        logic [LEN_W-1:0]     n_emit;
        logic [LEN_W-1:0]     last_idx;
        logic                 ovf;
        t_kind                next_kind;
        logic [WORD_W-1:0]    flag_shift;
        logic [FLAGS_W-1:0]   flags_left;
        logic [COUNT_W-1:0]   bytes_next;
        logic [ADDR_W-1:0]    match_dist;
        logic [BYTE_W-1:0]    lit;
    } t_plan;

endpackage

// ----- hdl/lz_window_decompressor_unit.sv -----
// top level of the lz window decompressor: flag tracking, copy engine, output register
// depends on lzwd_pkg, lzwd_item_decode, lzwd_ram and assert_macros.svh
//
//  channel   | direction | payload
//  ----------+-----------+----------------------------------------------------
//  s_axis    | in        | tdata: data_word; tlast: last_item
//  m_axis    | out       | tdata: out_byte; tlast: last_of_run;
//            |           | tuser: byte_valid, next_kind, overflow, stream_done
//  cfg       | in        | wr_en / wr_data: max_output_bytes
//
// control word and literal: a single result each; match: len bytes, copied while m_axis is not
// stalled (3..18 bytes, one window read and one write per cycle on the single ram port pair)
// the history window needs no clearing pass: a fill pointer plus a wrapped flag
// make unwritten entries read as zero, so the block is ready right after reset
// reset is synchronous, active low; the window contents are not reset
// a stall on m_axis freezes the copy engine; s_axis takes an item as soon as the
// previous item has passed its last byte on from the byte stage
`include "assert_macros.svh"

module lz_window_decompressor_unit
    import lzwd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input items
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [15:0]         s_axis_tdata,   // [15:0] data_word
    input  logic                s_axis_tlast,   // last_item
    // result items
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [7:0]          m_axis_tdata,   // [7:0] out_byte
    output logic                m_axis_tlast,   // last_of_run
    output logic [7:0]          m_axis_tuser,   // [0] byte_valid, [2:1] next_kind,
                                                // [3] overflow, [4] stream_done, rest 0
    // configuration
    input  logic                i_cfg_wr_en,
    input  logic [COUNT_W-1:0]  i_cfg_wr_data   // max_output_bytes
);

    // item-level state
    logic [COUNT_W-1:0] r_max;
    logic [WORD_W-1:0]  r_shift;
    logic [FLAGS_W-1:0] r_left;
    logic [COUNT_W-1:0] r_bw;
    logic               r_ovf;

    // current item
    logic               r_busy;
    t_kind              r_mode;
    t_kind              r_kind_out;
    logic [LEN_W-1:0]   r_len;
    logic [LEN_W-1:0]   r_n_emit;
    logic [LEN_W-1:0]   r_last_idx;
    logic               r_last_in;

    // window pointers
    logic [ADDR_W-1:0]  r_wpos;
    logic               r_wrap;
    logic [ADDR_W-1:0]  r_src;
    logic [LEN_W-1:0]   r_rd_cnt;

    // byte stage, valid in the cycle after the window read is issued
    logic               r_b_valid;
    logic [LEN_W-1:0]   r_b_idx;
    logic               r_b_lit;
    logic               r_b_zero;
    logic               r_b_fwd;
    logic [BYTE_W-1:0]  r_fwd_data;
    logic [BYTE_W-1:0]  r_lit;

    // output register
    logic               r_ov;
    logic [BYTE_W-1:0]  r_o_byte;
    logic               r_o_bvalid;
    logic               r_o_last;
    t_kind              r_o_kind;
    logic               r_o_ovf;
    logic               r_o_done;

    t_plan              plan;
    logic               accept;
    logic               adv;
    logic               rd_issue;
    logic               b_consume;
    logic               b_last;
    logic               b_emit;
    logic               b_is_byte;
    logic [BYTE_W-1:0]  b_data;
    logic [BYTE_W-1:0]  ram_rdata;
    logic               ram_we;
    logic [ADDR_W-1:0]  n_wpos;
    logic               n_wrap;
    logic               rd_written;

    lzwd_item_decode u_decode (
        .i_word          (s_axis_tdata),
        .i_flag_shift    (r_shift),
        .i_flags_left    (r_left),
        .i_bytes_written (r_bw),
        .i_max_bytes     (r_max),
        .i_ovf           (r_ovf),
        .o_plan          (plan)
    );

    lzwd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (WINDOW_BYTES)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wpos),
        .i_wdata (b_data),
        .i_re    (rd_issue),
        .i_raddr (r_src),
        .o_rdata (ram_rdata)
    );

    // the copy engine moves only when the output register can take a result
    assign adv       = ~r_ov | m_axis_tready;
    assign accept    = s_axis_tvalid & ~r_busy;
    assign rd_issue  = r_busy & (r_mode == KIND_MATCH) & (r_rd_cnt < r_len) & adv;
    assign b_consume = r_b_valid & adv;
    assign b_last    = (r_b_idx == r_len - LEN_W'(1));
    assign b_is_byte = (r_b_idx < r_n_emit);
    // a suppressed or control item still leaves one flag-only result
    assign b_emit    = b_is_byte | ((r_n_emit == '0) & (r_b_idx == r_last_idx));
    assign ram_we    = b_consume & (r_mode != KIND_CONTROL);

    always_comb begin
        if (r_b_lit) begin
            b_data = r_lit;
        end else if (r_b_zero) begin
            b_data = '0;
        end else if (r_b_fwd) begin
            b_data = r_fwd_data;
        end else begin
            b_data = ram_rdata;
        end
    end

    // fill state as seen by the read issued this cycle, including the
    // write of the previous byte that lands at the same edge
    assign n_wpos     = ram_we ? r_wpos + ADDR_W'(1) : r_wpos;
    assign n_wrap     = r_wrap | (ram_we & (r_wpos == '1));
    assign rd_written = n_wrap | (r_src < n_wpos);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max     <= MAX_BYTES_RST;
            r_shift   <= '0;
            r_left    <= '0;
            r_bw      <= '0;
            r_ovf     <= 1'b0;
            r_busy    <= 1'b0;
            r_wpos    <= '0;
            r_wrap    <= 1'b0;
            r_b_valid <= 1'b0;
            r_ov      <= 1'b0;
            r_rd_cnt  <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_max <= i_cfg_wr_data;
            end

            // new item: flag and limit bookkeeping is settled up front
            if (accept) begin
                r_busy     <= 1'b1;
                r_mode     <= plan.kind;
                r_len      <= plan.len;
                r_n_emit   <= plan.n_emit;
                r_last_idx <= plan.last_idx;
                r_kind_out <= plan.next_kind;
                r_ovf      <= plan.ovf;
                r_bw       <= plan.bytes_next;
                r_shift    <= plan.flag_shift;
                r_left     <= plan.flags_left;
                r_last_in  <= s_axis_tlast;
                r_src      <= r_wpos - plan.match_dist;
                r_rd_cnt   <= '0;
                r_lit      <= plan.lit;
                if (plan.kind != KIND_MATCH) begin
                    r_b_valid <= 1'b1;
                    r_b_idx   <= '0;
                    r_b_lit   <= 1'b1;
                end
            end

            // window read for the next match byte
            if (rd_issue) begin
                r_src      <= r_src + ADDR_W'(1);
                r_rd_cnt   <= r_rd_cnt + LEN_W'(1);
                r_b_valid  <= 1'b1;
                r_b_idx    <= r_rd_cnt;
                r_b_lit    <= 1'b0;
                r_b_zero   <= ~rd_written;
                // same entry written this edge: take the byte from the write side
                r_b_fwd    <= ram_we & (r_wpos == r_src);
                r_fwd_data <= b_data;
            end else if (b_consume) begin
                r_b_valid <= 1'b0;
            end

            if (b_consume) begin
                r_wpos <= n_wpos;
                r_wrap <= n_wrap;
                if (b_last) begin
                    r_busy <= 1'b0;
                end
            end

            if (b_consume & b_emit) begin
                r_ov <= 1'b1;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (b_consume & b_emit) begin
            r_o_byte   <= b_is_byte ? b_data : '0;
            r_o_bvalid <= b_is_byte;
            r_o_last   <= (r_b_idx == r_last_idx);
            r_o_kind   <= r_kind_out;
            r_o_ovf    <= r_ovf;
            r_o_done   <= (r_b_idx == r_last_idx) & r_last_in;
        end
    end

    assign s_axis_tready = ~r_busy;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_o_byte;
    assign m_axis_tlast  = r_o_last;
    assign m_axis_tuser  = {3'b000, r_o_done, r_o_ovf, r_o_kind, r_o_bvalid};

    // read and write of one entry at the same edge must select the forwarded byte
    `ASSERT_NEXT(a_fwd_on_collision, rd_issue && ram_we && (r_wpos == r_src), r_b_fwd, "window collision not forwarded")
    // the byte stage only holds data for an item in progress
    `ASSERT_IMPL(a_stage_in_item, r_b_valid, r_busy, "byte stage valid outside an item")
    // the copy never reads past the match length
    `ASSERT_IMPL(a_reads_bounded, r_busy, r_rd_cnt <= r_len, "window reads exceed match length")
    // every window write moves the fill pointer by one
    `ASSERT_NEXT(a_wpos_step, ram_we, r_wpos == $past(r_wpos) + ADDR_W'(1), "write pointer did not advance")

endmodule

// ----- hdl/lzwd_ram.sv -----
// generic simple dual-port ram, one write and one registered read port
// no dependencies; used for the history window
module lzwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/lzwd_item_decode.sv -----
// decodes one input word against flag state and output limit into an item plan
// depends on lzwd_pkg
module lzwd_item_decode
    import lzwd_pkg::*;
(
    input  logic [WORD_W-1:0]  i_word,
    input  logic [WORD_W-1:0]  i_flag_shift,
    input  logic [FLAGS_W-1:0] i_flags_left,
    input  logic [COUNT_W-1:0] i_bytes_written,
    input  logic [COUNT_W-1:0] i_max_bytes,
    input  logic               i_ovf,
    output t_plan              o_plan
);

    logic [COUNT_W-1:0] remaining;
    logic               fits;

    always_comb begin
        o_plan = '0;
        o_plan.match_dist = i_word[WORD_W-1:4];
        o_plan.lit        = i_word[BYTE_W-1:0];

        if (i_flags_left == '0) begin
            o_plan.kind       = KIND_CONTROL;
            o_plan.flag_shift = i_word;
            o_plan.flags_left = FLAGS_PER_CTRL;
            o_plan.len        = LEN_W'(1);
        end else begin
            o_plan.kind       = i_flag_shift[WORD_W-1] ? KIND_MATCH : KIND_LITERAL;
            o_plan.flag_shift = {i_flag_shift[WORD_W-2:0], 1'b0};
            o_plan.flags_left = i_flags_left - FLAGS_W'(1);
            o_plan.len        = i_flag_shift[WORD_W-1]
                              ? MATCH_LEN_BASE - {1'b0, i_word[3:0]} : LEN_W'(1);
        end

        // bytes still allowed under the limit
        remaining = (i_max_bytes > i_bytes_written) ? i_max_bytes - i_bytes_written : '0;
        fits      = remaining >= COUNT_W'(o_plan.len);

        if (o_plan.kind == KIND_CONTROL) begin
            o_plan.n_emit = '0;
            o_plan.ovf    = i_ovf;
        end else begin
            o_plan.n_emit = fits ? o_plan.len : remaining[LEN_W-1:0];
            o_plan.ovf    = i_ovf | ~fits;
        end

        o_plan.bytes_next = i_bytes_written + COUNT_W'(o_plan.n_emit);
        o_plan.last_idx   = (o_plan.n_emit == '0) ? o_plan.len - LEN_W'(1)
                                                  : o_plan.n_emit - LEN_W'(1);

        if (o_plan.flags_left == '0) begin
            o_plan.next_kind = KIND_CONTROL;
        end else if (o_plan.flag_shift[WORD_W-1]) begin
            o_plan.next_kind = KIND_MATCH;
        end else begin
            o_plan.next_kind = KIND_LITERAL;
        end
    end

endmodule

// ----- test/tb_lz_window_decompressor_unit.sv -----
// testbench for the lz window decompressor: directed and random word streams
// checked against an in-bench model of the flag, window and output limit logic
// depends on lzwd_pkg and lz_window_decompressor_unit
`timescale 1ns / 1ps

module tb_lz_window_decompressor_unit;
    import lzwd_pkg::*;

    // one result item as seen on m_axis
    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       run_end;
        t_kind      kind_after;
        logic       ovf;
        logic       done;
    } t_out_item;

    // one input item waiting for the driver
    typedef struct packed {
        logic [15:0] word;
        logic        last;
    } t_in_item;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [15:0]         s_axis_tdata = '0;   // [15:0] data_word
    logic                s_axis_tlast = 1'b0; // last_item
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [7:0]          m_axis_tdata;        // [7:0] out_byte
    logic                m_axis_tlast;        // last_of_run
    logic [7:0]          m_axis_tuser;        // [0] byte_valid, [2:1] next_kind,
                                              // [3] overflow, [4] stream_done, rest 0
    logic                i_cfg_wr_en = 1'b0;
    logic [COUNT_W-1:0]  i_cfg_wr_data = '0;  // max_output_bytes

    lz_window_decompressor_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_in_item  pending_words[$];
    t_out_item expected_out[$];
    t_out_item cur_run[$];
    int        n_errors = 0;

    // model state of the decompressor
    logic [7:0]         win_hist [WINDOW_BYTES];
    logic [ADDR_W-1:0]  win_pos;
    logic [15:0]        flag_bits;
    logic [FLAGS_W-1:0] flags_pending;
    logic [COUNT_W-1:0] out_count;
    logic               ovf_seen;
    logic [COUNT_W-1:0] byte_limit;

    // parse position of the stimulus generator, mirrors the block's flag walk
    logic [15:0]        gen_flags = '0;
    logic [FLAGS_W-1:0] gen_left = '0;

    // store one byte in the history, emit it unless the limit is reached
    function automatic void put_byte(logic [7:0] b);
        t_out_item r;
        win_hist[win_pos] = b;
        win_pos = win_pos + ADDR_W'(1);
        if (out_count < byte_limit) begin
            out_count = out_count + COUNT_W'(1);
            r = '0;
            r.data = b;
            r.valid = 1'b1;
            cur_run.insert(cur_run.size(), r);
        end else begin
            ovf_seen = 1'b1;
        end
    endfunction

    // work out the results of one accepted word and queue them
    function automatic void decode_word(logic [15:0] word, logic last);
        logic              flag;
        logic [ADDR_W-1:0] src;
        int unsigned       run_len;
        t_kind             after;
        t_out_item         r;
        cur_run.delete();
        if (flags_pending == 0) begin
            // control word: load 16 flags
            flag_bits = word;
            flags_pending = FLAGS_PER_CTRL;
        end else begin
            flag = flag_bits[15];
            flag_bits = flag_bits << 1;
            flags_pending = flags_pending - FLAGS_W'(1);
            if (!flag) begin
                put_byte(word[7:0]);
            end else begin
                // byte by byte, so an overlapping copy repeats bytes
                src = win_pos - word[15:4];
                run_len = 32'(MATCH_LEN_BASE) - 32'(word[3:0]);
                for (int i = 0; i < run_len; i++) begin
                    put_byte(win_hist[src]);
                    src = src + ADDR_W'(1);
                end
            end
        end
        // control word or fully suppressed item: one empty result
        if (cur_run.size() == 0) begin
            r = '0;
            cur_run.insert(0, r);
        end
        if (flags_pending == 0) begin
            after = KIND_CONTROL;
        end else begin
            after = flag_bits[15] ? KIND_MATCH : KIND_LITERAL;
        end
        for (int k = 0; k < cur_run.size(); k++) begin
            r = cur_run[k];
            r.run_end = (k == cur_run.size() - 1);
            r.kind_after = after;
            r.ovf = ovf_seen;
            r.done = (k == cur_run.size() - 1) ? last : 1'b0;
            expected_out.insert(expected_out.size(), r);
        end
    endfunction

    // queue a word for the driver and advance the generator's flag walk
    function automatic void queue_word(logic [15:0] word, logic last);
        t_in_item it;
        it.word = word;
        it.last = last;
        pending_words.insert(pending_words.size(), it);
        if (gen_left == 0) begin
            gen_flags = word;
            gen_left = FLAGS_PER_CTRL;
        end else begin
            gen_flags = gen_flags << 1;
            gen_left = gen_left - FLAGS_W'(1);
        end
    endfunction

    // random words shaped for the slot the block is at, with some noise mixed in
    function automatic void queue_random(int n);
        logic [15:0] word;
        logic [11:0] back_dist;
        int          pick;
        for (int i = 0; i < n; i++) begin
            if (gen_left == 0) begin
                pick = $urandom_range(0, 9);
                word = (pick == 0) ? 16'hFFFF : (pick == 1) ? 16'h0000 : 16'($urandom);
            end else if (!gen_flags[15]) begin
                word = 16'($urandom);
            end else begin
                pick = $urandom_range(0, 19);
                if (pick == 0) begin
                    back_dist = '0;
                end else if (pick == 1) begin
                    back_dist = 12'($urandom_range(2048, 4095));
                end else if (pick < 5) begin
                    back_dist = 12'($urandom_range(1, 4095));
                end else begin
                    back_dist = 12'($urandom_range(1, 48));
                end
                word = {back_dist, 4'($urandom_range(0, 15))};
            end
            // noise: a word of any shape in whatever slot comes up
            if ($urandom_range(0, 9) == 0) begin
                word = 16'($urandom);
            end
            queue_word(word, $urandom_range(0, 19) == 0);
        end
    endfunction

    // wait until the block has nothing left in flight
    task automatic wait_idle();
        while (pending_words.size() != 0 || s_axis_tvalid || expected_out.size() != 0) begin
            @(negedge i_clk);
        end
        // the wait covers the longest match, 18 bytes, and the pipeline behind it
        repeat (24) @(negedge i_clk);
    endtask

    task automatic write_limit(logic [COUNT_W-1:0] value);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= value;
        byte_limit = value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // ---------------------------------------------------------------- driver
    logic in_took = 1'b0;
    int   burst_left = 0;
    int   gap_left = 0;

    always @(negedge i_clk) begin
        t_in_item it;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_took) begin
            if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_words.size() != 0) begin
                it = pending_words.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= it.word;
                s_axis_tlast <= it.last;
                // end of a burst: random gap, often none
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left--;
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver stall pattern: one of four modes, drawn anew at random
    int rx_cyc = 0;
    int rx_mode = 0;

    always @(negedge i_clk) begin
        rx_cyc++;
        if (rx_cyc % 97 == 0) begin
            rx_mode = $urandom_range(0, 3);
        end
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= $urandom_range(0, 1);
            2: m_axis_tready <= (rx_cyc % 4 != 0);
            default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // --------------------------------------------------------------- monitor
    always @(posedge i_clk) begin
        t_out_item got;
        t_out_item want;
        in_took <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                decode_word(s_axis_tdata, s_axis_tlast);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.data = m_axis_tdata;
                got.valid = m_axis_tuser[0];
                got.run_end = m_axis_tlast;
                got.kind_after = t_kind'(m_axis_tuser[2:1]);
                got.ovf = m_axis_tuser[3];
                got.done = m_axis_tuser[4];
                if (expected_out.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10) begin
                        $display("%0t: result with nothing expected: data=%h tuser=%h last=%b",
                                 $realtime, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    end
                end else begin
                    want = expected_out.pop_front();
                    if (got !== want) begin
                        n_errors++;
                        if (n_errors <= 10) begin
                            $display("%0t: mismatch exp data=%h v=%b end=%b kind=%0d ovf=%b done=%b",
                                     $realtime, want.data, want.valid, want.run_end,
                                     want.kind_after, want.ovf, want.done);
                            $display("%0t:          got data=%h v=%b end=%b kind=%0d ovf=%b done=%b",
                                     $realtime, got.data, got.valid, got.run_end,
                                     got.kind_after, got.ovf, got.done);
                        end
                    end
                end
            end
        end
    end

    // -------------------------------------------------------------- sequence
    initial begin
        for (int i = 0; i < WINDOW_BYTES; i++) begin
            win_hist[i] = '0;
        end
        win_pos = '0;
        flag_bits = '0;
        flags_pending = '0;
        out_count = '0;
        ovf_seen = 1'b0;
        byte_limit = MAX_BYTES_RST;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_limit(MAX_BYTES_RST);

        // flags 0011 1010 0100 1100: literals, matches, last item mid-group
        queue_word(16'h3A4C, 1'b0);
        queue_word(16'hFF00, 1'b0);  // literal 00, upper byte set
        queue_word(16'h00FF, 1'b0);  // literal ff
        queue_word(16'h001F, 1'b0);  // distance 1, length 3: overlapping repeat
        queue_word(16'h0000, 1'b0);  // distance 0, length 18: reads a full window back
        queue_word(16'hFFF8, 1'b0);  // distance 4095: wraps into unwritten entries
        queue_word(16'h12A5, 1'b1);  // last item on a literal
        queue_word(16'h002E, 1'b0);
        queue_word(16'h3C5A, 1'b0);
        queue_word(16'h00C3, 1'b0);
        queue_word(16'h007D, 1'b0);
        queue_word(16'h8001, 1'b0);
        queue_word(16'h7F7E, 1'b0);
        queue_word(16'h0140, 1'b0);  // distance 20, length 18
        queue_word(16'h0039, 1'b0);
        queue_word(16'hABCD, 1'b0);
        queue_word(16'h5432, 1'b1);
        queue_word(16'hFFFF, 1'b1);  // control word carrying last item, all matches next
        queue_random(140);
        wait_idle();

        // limit a little above what has been emitted: overflow hits mid-stream
        write_limit(out_count + COUNT_W'($urandom_range(5, 40)));
        queue_random(80);
        wait_idle();

        // limit zero, below the count: every byte suppressed
        write_limit('0);
        queue_random(40);
        wait_idle();

        write_limit(MAX_BYTES_RST);
        queue_random(110);
        wait_idle();

        if (n_errors == 0) begin
            $display("PASS lz_window_decompressor_unit");
        end else begin
            $display("FAIL lz_window_decompressor_unit");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("FAIL lz_window_decompressor_unit");
        $finish;
    end

endmodule
